/* design/rgbl_pkg.sv */
package rgbl_pkg;

  localparam int PIXELS = 65536;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CH = 3;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_MEAN0 = 3'd1;
  localparam logic [2:0] REG_MEAN1 = 3'd2;
  localparam logic [2:0] REG_MEAN2 = 3'd3;
  localparam logic [2:0] REG_VAR0 = 3'd4;
  localparam logic [2:0] REG_VAR1 = 3'd5;
  localparam logic [2:0] REG_VAR2 = 3'd6;

  localparam longint HALF_LN2PI_Q28 = 64'sd246675684;
  localparam longint HALF_LN2_Q16 = 64'sd22713;

  localparam int DIV_STEPS = 43;
  localparam int LAT = DIV_STEPS;
  localparam int LOG_DLY = DIV_STEPS - 13;

  typedef struct packed {
    logic [15:0] alpha;
    logic [2:0][15:0] mean0;
    logic [2:0][15:0] var0;
  } cfg_t;

  function automatic logic [15:0] clamp16(input logic signed [33:0] v);
    logic [15:0] r;
    if (v < 0) r = 16'd0;
    else if (v > 34'sd65535) r = 16'hFFFF;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] alpha, input logic [15:0] old,
                                        input logic [15:0] tgt);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [33:0] s;
    d = $signed({1'b0, tgt}) - $signed({1'b0, old});
    p = $signed({1'b0, alpha}) * d + 34'sd32768;
    s = $signed({18'd0, old}) + (p >>> 16);
    return clamp16(s);
  endfunction

  function automatic logic [3:0] msb_pos(input logic [15:0] v);
    logic [3:0] e;
    e = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) e = 4'(i);
    end
    return e;
  endfunction

endpackage

/* design/running_gaussian_background_likelihood_top.sv */
// Running Gaussian background model: one pixel word per clock in, one likelihood word per
// clock out while the output register is not stalled. The mean and variance memories are
// read at acceptance and written back as the pixel leaves stage 4; a younger pixel at the same
// address between that read and the write-back, including the cycle of the write itself,
// is served by forwarding. The likelihood path is a 43-stage restoring divider per channel
// with a 12-stage squaring log2 unit beside it, followed by the output register, which also
// rounds and saturates. The pipeline advances whenever the output register is empty or being
// drained, so a stall holds every stage. Until a pixel flagged last_in_frame has passed the
// update, stored values read as the initial registers. No clearing pass is needed.
module running_gaussian_background_likelihood_top import rgbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        pixel_index,
  input  logic [7:0]         sample_ch0,
  input  logic [7:0]         sample_ch1,
  input  logic [7:0]         sample_ch2,
  input  logic               update_enable,
  input  logic               last_in_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] log_likelihood,
  output logic               variance_floored,
  output logic               end_of_frame,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  cfg_t cfg;
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= 16'd655;
      cfg.mean0 <= {3{16'd32768}};
      cfg.var0 <= {3{16'd655}};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA: cfg.alpha <= cfg_data;
        REG_MEAN0: cfg.mean0[0] <= cfg_data;
        REG_MEAN1: cfg.mean0[1] <= cfg_data;
        REG_MEAN2: cfg.mean0[2] <= cfg_data;
        REG_VAR0: cfg.var0[0] <= cfg_data;
        REG_VAR1: cfg.var0[1] <= cfg_data;
        REG_VAR2: cfg.var0[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [47:0] mean_mem [PIXELS];
  logic [47:0] var_mem [PIXELS];

  // s1: memory read. s2: mean update. s3: d2. s4: var update, written back as it leaves.
  logic v1, v2, v3, v4;
  logic [15:0] idx1, idx2, idx3, idx4;
  logic inr1, inr2, inr3, inr4;
  logic upd1, upd2, upd3;
  logic last1, last2, last3, last4;
  logic st1;
  logic [2:0][15:0] x1, x2;
  logic [47:0] rm1, rv1;
  logic [2:0][15:0] m2, m3, v3r, m4, v4r;
  logic [2:0][15:0] d3, d4;
  logic started;
  logic wb1;
  logic [2:0][15:0] wm1, wv1;

  logic in_rng;
  assign in_rng = 32'(pixel_index) < PIXELS;

  always_ff @(posedge clk) begin
    if (adv) begin
      rm1 <= mean_mem[pixel_index[ADDR_W-1:0]];
      rv1 <= var_mem[pixel_index[ADDR_W-1:0]];
      wb1 <= v4 && inr4 && idx4 == pixel_index;
      wm1 <= m4;
      wv1 <= v4r;
      idx1 <= pixel_index;
      inr1 <= in_rng;
      upd1 <= update_enable;
      last1 <= last_in_frame;
      x1[0] <= {sample_ch0, sample_ch0};
      x1[1] <= {sample_ch1, sample_ch1};
      x1[2] <= {sample_ch2, sample_ch2};
    end
  end

  // Operand selection with forwarding from stages 2..4 and from the write made at the read.
  logic [2:0][15:0] m_sel, v_sel;
  logic fw_m2, fw_m3, fw_m4;
  always_comb begin
    m_sel = rm1;
    v_sel = rv1;
    fw_m2 = v2 && inr2 && idx2 == idx1;
    fw_m3 = v3 && inr3 && idx3 == idx1;
    fw_m4 = v4 && inr4 && idx4 == idx1;
    if (!(inr1 && st1)) begin
      m_sel = cfg.mean0;
      v_sel = cfg.var0;
    end else if (fw_m2) begin
      m_sel = m2;
      v_sel = 48'(0);
    end else if (fw_m3) begin
      m_sel = m3;
      v_sel = 48'(0);
    end else if (fw_m4) begin
      m_sel = m4;
      v_sel = v4r;
    end else if (wb1) begin
      m_sel = wm1;
      v_sel = wv1;
    end
  end

  // Variance needs the final value; forward it into stage 2 input late via delayed select.
  logic [1:0] vsrc2;
  logic [2:0][15:0] vmem2;
  logic [2:0][15:0] m_new;
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      m_new[c] = upd1 ? blend(cfg.alpha, m_sel[c], x1[c]) : m_sel[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2 <= m_new;
      vmem2 <= v_sel;
      vsrc2 <= (!(inr1 && st1)) ? 2'd0 : fw_m2 ? 2'd1 : fw_m3 ? 2'd2 : 2'd0;
      x2 <= x1;
      idx2 <= idx1;
      inr2 <= inr1;
      upd2 <= upd1;
      last2 <= last1;
    end
  end

  // Stage 2 to 3: d2; resolve variance operand (older items now at stages 3,4).
  logic [2:0][15:0] d_new;
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      logic signed [16:0] df;
      logic [33:0] sq;
      df = $signed({1'b0, x2[c]}) - $signed({1'b0, m2[c]});
      sq = 34'(df * df) + 34'd32768;
      d_new[c] = clamp16($signed({1'b0, sq[33:16]}));
    end
  end

  logic [1:0] vsrc3;
  always_ff @(posedge clk) begin
    if (adv) begin
      d3 <= d_new;
      m3 <= m2;
      v3r <= (vsrc2 == 2'd2) ? v4r : vmem2;
      vsrc3 <= (vsrc2 == 2'd1) ? 2'd1 : 2'd0;
      idx3 <= idx2;
      inr3 <= inr2;
      upd3 <= upd2;
      last3 <= last2;
    end
  end

  logic [2:0][15:0] v_op, v_new;
  always_comb begin
    v_op = (vsrc3 == 2'd1) ? v4r : v3r;
    for (int c = 0; c < CH; c++) begin
      v_new[c] = upd3 ? blend(cfg.alpha, v_op[c], d3[c]) : v_op[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v4r <= v_new;
      m4 <= m3;
      d4 <= d3;
      idx4 <= idx3;
      inr4 <= inr3;
      last4 <= last3;
    end
  end

  // Write at the end of stage 4; started rises as a pixel flagged last_in_frame leaves.
  always_ff @(posedge clk) begin
    if (adv && v4 && inr4) begin
      mean_mem[idx4[ADDR_W-1:0]] <= m4;
      var_mem[idx4[ADDR_W-1:0]] <= v4r;
    end
  end

  // st1 is model_started as seen by the item in stage 1, counting older last pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      started <= 1'b0;
      st1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1; v3 <= v2; v4 <= v3;
      if (v4 && last4) started <= 1'b1;
      st1 <= started || (v4 && last4) || (v3 && last3) || (v2 && last2) || (v1 && last1);
    end
  end

  // Likelihood back end.
  logic [2:0][15:0] vf;
  logic flo4;
  always_comb begin
    for (int c = 0; c < CH; c++) vf[c] = (v4r[c] == 16'd0) ? 16'd1 : v4r[c];
    flo4 = (v4r[0] == 16'd0) || (v4r[1] == 16'd0) || (v4r[2] == 16'd0);
  end

  logic [2:0][42:0] quo;
  logic [2:0][15:0] lg;
  logic [2:0][15:0] lgd;
  for (genvar c = 0; c < CH; c++) begin : g_ch
    rgbl_div u_div (.clk(clk), .en(adv), .num({d4[c], 27'd0}), .den(vf[c]), .quo(quo[c]));
    rgbl_log2 u_log (.clk(clk), .en(adv), .v(vf[c]), .lg(lg[c]));
  end

  logic [LOG_DLY-1:0][47:0] lgq;
  always_ff @(posedge clk) begin
    if (adv) begin
      lgq[0] <= lg;
      for (int i = 1; i < LOG_DLY; i++) lgq[i] <= lgq[i-1];
    end
  end
  assign lgd = lgq[LOG_DLY-1];

  logic signed [63:0] slog, tt, tt_q;
  always_comb begin
    slog = 64'(lgd[0]) + 64'(lgd[1]) + 64'(lgd[2]);
    tt = HALF_LN2PI_Q28 + (slog - 64'sd196608) * HALF_LN2_Q16;
  end
  always_ff @(posedge clk) begin
    if (adv) tt_q <= tt;
  end

  logic [LAT-1:0] vq, lq, fq;
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (adv) begin
      vq <= {vq[LAT-2:0], v4};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lq <= {lq[LAT-2:0], last4};
      fq <= {fq[LAT-2:0], flo4};
    end
  end

  logic signed [63:0] ratios, ll, rs;
  logic signed [31:0] ll_sat;
  always_comb begin
    ratios = 64'(quo[0]) + 64'(quo[1]) + 64'(quo[2]);
    ll = -ratios - tt_q + 64'sd524288;
    rs = ll >>> 20;
    if (rs > 64'sd2147483647) ll_sat = 32'sh7FFFFFFF;
    else if (rs < -64'sd2147483648) ll_sat = 32'sh80000000;
    else ll_sat = rs[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vq[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      log_likelihood <= ll_sat;
      variance_floored <= fq[LAT-1];
      end_of_frame <= lq[LAT-1];
    end
  end
endmodule

/* design/rgbl_div.sv */
module rgbl_div import rgbl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [42:0] num,
  input  logic [15:0] den,
  output logic [42:0] quo
);
  logic [DIV_STEPS-1:0][42:0] q;
  logic [DIV_STEPS-1:0][16:0] r;
  logic [DIV_STEPS-1:0][15:0] d;

  always_ff @(posedge clk) begin
    logic [42:0] qi;
    logic [16:0] ri;
    logic [15:0] di;
    logic [17:0] sh;
    logic [17:0] df;
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        if (s == 0) begin
          qi = num;
          ri = '0;
          di = den;
        end else begin
          qi = q[s-1];
          ri = r[s-1];
          di = d[s-1];
        end
        sh = {ri, qi[42]};
        df = sh - {2'b0, di};
        d[s] <= di;
        if (!df[17]) begin
          r[s] <= df[16:0];
          q[s] <= {qi[41:0], 1'b1};
        end else begin
          r[s] <= sh[16:0];
          q[s] <= {qi[41:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[DIV_STEPS-1];
endmodule

/* design/rgbl_log2.sv */
module rgbl_log2 import rgbl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] v,
  output logic [15:0] lg
);
  logic [16:0] n0;
  logic [15:0] acc0;
  logic [11:0][16:0] n;
  logic [11:0][15:0] acc;

  assign n0 = 17'({1'b0, v} << (4'd15 - msb_pos(v)));
  assign acc0 = {msb_pos(v), 12'd0};

  always_ff @(posedge clk) begin
    logic [16:0] ni;
    logic [15:0] ai;
    logic [33:0] p;
    logic [18:0] sq;
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        if (k == 0) begin
          ni = n0;
          ai = acc0;
        end else begin
          ni = n[k-1];
          ai = acc[k-1];
        end
        p = ni * ni;
        sq = p[33:15];
        if (sq >= 19'd65536) begin
          n[k] <= sq[17:1];
          acc[k] <= ai | 16'(1 << (11 - k));
        end else begin
          n[k] <= sq[16:0];
          acc[k] <= ai;
        end
      end
    end
  end

  assign lg = acc[11];
endmodule

/* design/rgbl_checker.sv */
module rgbl_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] log_likelihood,
  input logic cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(log_likelihood))
    else $error("output word dropped during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("empty output blocks input");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind running_gaussian_background_likelihood_top rgbl_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .log_likelihood(log_likelihood),
  .cfg_ready(cfg_ready)
);

/* test/tb_running_gaussian_background_likelihood_top.sv */
`timescale 1ns / 1ps

module tb_running_gaussian_background_likelihood_top;
  import rgbl_pkg::*;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic        upd;
    logic        last;
  } pixel_word_t;

  typedef struct packed {
    logic signed [31:0] ll;
    logic               flr;
    logic               eof;
  } likelihood_word_t;

  typedef logic [2:0][15:0] triple_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic [15:0] pixel_index;
  logic [7:0] sample_ch0, sample_ch1, sample_ch2;
  logic update_enable, last_in_frame;
  logic out_valid, out_ready;
  logic signed [31:0] log_likelihood;
  logic variance_floored, end_of_frame;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  running_gaussian_background_likelihood_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] alpha_q;
  triple_t init_mean, init_var;
  triple_t mean_mem[int];
  triple_t var_mem[int];
  bit model_live;
  likelihood_word_t pending_q[$];
  int errors;
  int cycles = 0;
  int burst_left;
  logic [15:0] index_pool[$];
  logic [15:0] recent[$];
  pixel_word_t last_px;

  localparam int ROWS = 12;
  pixel_word_t directed[ROWS] = '{
    '{16'd0,     8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
    '{16'd65535, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
    '{16'd1,     8'd255, 8'd0,   8'd128, 1'b0, 1'b0},
    '{16'd2,     8'd0,   8'd255, 8'd0,   1'b1, 1'b0},
    '{16'd1,     8'd255, 8'd0,   8'd128, 1'b1, 1'b0},
    '{16'd1,     8'd255, 8'd0,   8'd128, 1'b1, 1'b0},
    '{16'd3,     8'd128, 8'd128, 8'd128, 1'b0, 1'b0},
    '{16'd43690, 8'd170, 8'd85,  8'd170, 1'b1, 1'b0},
    '{16'd21845, 8'd85,  8'd170, 8'd85,  1'b0, 1'b0},
    '{16'd65535, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
    '{16'd0,     8'd255, 8'd255, 8'd255, 1'b0, 1'b0},
    '{16'd2,     8'd128, 8'd127, 8'd1,   1'b1, 1'b0}
  };

  function automatic longint blend_q16(longint old, longint tgt);
    longint s;
    s = old + ((longint'(alpha_q) * (tgt - old) + 32768) >>> 16);
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return s;
  endfunction

  function automatic longint log2_q12(longint v);
    longint n, frac;
    int e;
    e = 0;
    frac = 0;
    while (e < 15 && (v >> (e + 1)) != 0) e++;
    n = v << (15 - e);
    for (int k = 0; k < 12; k++) begin
      n = (n * n) >> 15;
      frac = frac << 1;
      if (n >= 65536) begin
        n = n >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 4096 + frac;
  endfunction

  function automatic likelihood_word_t predict_likelihood(pixel_word_t p);
    triple_t m, v;
    logic [7:0] smp[3];
    longint ratios, slog, t, ll, x, diff, d2, vf, mc, vc;
    likelihood_word_t r;
    smp[0] = p.s0;
    smp[1] = p.s1;
    smp[2] = p.s2;
    ratios = 0;
    slog = 0;
    r.flr = 1'b0;
    if (model_live) begin
      m = mean_mem[p.idx];
      v = var_mem[p.idx];
    end else begin
      m = init_mean;
      v = init_var;
    end
    for (int c = 0; c < 3; c++) begin
      x = longint'(smp[c]) * 257;
      mc = m[c];
      vc = v[c];
      if (p.upd) mc = blend_q16(mc, x);
      diff = x - mc;
      d2 = (diff * diff + 32768) >> 16;
      if (d2 > 65535) d2 = 65535;
      if (p.upd) vc = blend_q16(vc, d2);
      m[c] = mc[15:0];
      v[c] = vc[15:0];
      vf = vc;
      if (vf == 0) begin
        vf = 1;
        r.flr = 1'b1;
      end
      ratios += (d2 << 27) / vf;
      slog += log2_q12(vf);
    end
    mean_mem[p.idx] = m;
    var_mem[p.idx] = v;
    if (p.last) model_live = 1'b1;
    t = HALF_LN2PI_Q28 + (slog - 48 * 4096) * HALF_LN2_Q16;
    ll = (-ratios - t + (longint'(1) << 19)) >>> 20;
    if (ll > 64'sd2147483647) ll = 64'sd2147483647;
    if (ll < -64'sd2147483648) ll = -64'sd2147483648;
    r.ll = ll[31:0];
    r.eof = p.last;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_pixel(pixel_word_t p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_index <= p.idx;
    sample_ch0 <= p.s0;
    sample_ch1 <= p.s1;
    sample_ch2 <= p.s2;
    update_enable <= p.upd;
    last_in_frame <= p.last;
    do @(posedge clk); while (!in_ready);
    pending_q = {pending_q, predict_likelihood(p)};
    last_px = p;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA: alpha_q = data;
      REG_MEAN0: init_mean[0] = data;
      REG_MEAN1: init_mean[1] = data;
      REG_MEAN2: init_mean[2] = data;
      REG_VAR0:  init_var[0] = data;
      REG_VAR1:  init_var[1] = data;
      REG_VAR2:  init_var[2] = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_model(logic [15:0] a, logic [15:0] m0, logic [15:0] m1, logic [15:0] m2,
                           logic [15:0] v0, logic [15:0] v1, logic [15:0] v2);
    write_reg(REG_ALPHA, a);
    write_reg(REG_MEAN0, m0);
    write_reg(REG_MEAN1, m1);
    write_reg(REG_MEAN2, m2);
    write_reg(REG_VAR0, v0);
    write_reg(REG_VAR1, v1);
    write_reg(REG_VAR2, v2);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sample(logic [7:0] prev);
    logic [7:0] s;
    case ($urandom_range(0, 5))
      0: s = 8'd0;
      1: s = 8'd255;
      2, 3: s = prev;
      default: s = 8'($urandom_range(0, 255));
    endcase
    return s;
  endfunction

  function automatic pixel_word_t random_pixel(bit fresh, bit may_end);
    pixel_word_t p;
    if (fresh) begin
      p.idx = 16'($urandom_range(0, 65535));
    end else if (recent.size() != 0 && $urandom_range(0, 2) == 0) begin
      p.idx = recent[$urandom_range(0, recent.size() - 1)];
    end else begin
      p.idx = index_pool[$urandom_range(0, index_pool.size() - 1)];
    end
    p.s0 = pick_sample(last_px.s0);
    p.s1 = pick_sample(last_px.s1);
    p.s2 = pick_sample(last_px.s2);
    p.upd = ($urandom_range(0, 3) != 0);
    p.last = may_end && ($urandom_range(0, 24) == 0);
    return p;
  endfunction

  task automatic note_index(logic [15:0] idx);
    index_pool = {index_pool, idx};
    recent = {recent, idx};
    if (recent.size() > 4) void'(recent.pop_front());
  endtask

  always @(posedge clk) begin
    likelihood_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("unexpected output word: ll %0d", log_likelihood);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (log_likelihood !== want.ll)
          report_mismatch("log_likelihood", log_likelihood, want.ll);
        if (variance_floored !== want.flr)
          report_mismatch("variance_floored", variance_floored, want.flr);
        if (end_of_frame !== want.eof)
          report_mismatch("end_of_frame", end_of_frame, want.eof);
      end
    end
  end

  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 9) != 0);
      default: out_ready <= cycles[2];
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    pixel_word_t p;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel_index <= '0;
    sample_ch0 <= '0;
    sample_ch1 <= '0;
    sample_ch2 <= '0;
    update_enable <= 1'b0;
    last_in_frame <= 1'b0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    errors = 0;
    burst_left = 0;
    model_live = 1'b0;
    last_px = '0;
    alpha_q = 16'd655;
    init_mean = {3{16'd32768}};
    init_var = {3{16'd655}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first frame stays open until the last pixel sent after the second
    // set_model call, so that each setting of the initial mean and variance is seen.
    for (int i = 0; i < ROWS; i++) begin
      send_pixel(directed[i]);
      note_index(directed[i].idx);
    end
    drain();

    set_model(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 44; i++) begin
      p = random_pixel(1'b1, 1'b0);
      send_pixel(p);
      note_index(p.idx);
    end
    drain();

    set_model(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 44; i++) begin
      p = random_pixel(1'b1, 1'b0);
      p.last = (i == 43);
      send_pixel(p);
      note_index(p.idx);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(REG_ALPHA, 16'hFFFF);
        1: write_reg(REG_ALPHA, 16'd0);
        2: write_reg(REG_ALPHA, 16'(($urandom_range(0, 65535))));
        3: write_reg(REG_ALPHA, 16'd655);
        default: write_reg(REG_ALPHA, 16'(($urandom_range(30000, 65535))));
      endcase
      cfg_valid <= 1'b0;
      for (int i = 0; i < 70; i++) begin
        p = random_pixel(1'b0, 1'b1);
        send_pixel(p);
        note_index(p.idx);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
